// File: sv/ugot_pkg.sv
// Shared types, codes and constants of the uniform grid occupancy table.
package ugot_pkg;

  // Store geometry
  localparam int unsigned MAX_CELLS = 4096;
  localparam int unsigned CELL_W    = $clog2(MAX_CELLS);
  localparam int unsigned ID_WIDTH  = 16;
  localparam int unsigned RAM_W     = ID_WIDTH + 1;
  localparam int unsigned MAX_SIDE  = 64;
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE);
  localparam int unsigned LIM_W     = SIDE_W + 1;

  // Operation kinds
  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_MOVE_POS  = 3'd1;
  localparam logic [2:0] KIND_MOVE_CELL = 3'd2;
  localparam logic [2:0] KIND_QUERY     = 3'd3;
  localparam logic [2:0] KIND_CELL_POS  = 3'd4;

  // Neighbour slot states and special slots
  localparam logic [1:0] SLOT_OUTSIDE  = 2'd0;
  localparam logic [1:0] SLOT_EMPTY    = 2'd1;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd2;
  localparam logic [3:0] SLOT_FIRST    = 4'd0;
  localparam logic [3:0] SLOT_BEFORE_C = 4'd3;
  localparam logic [3:0] SLOT_AFTER_C  = 4'd5;
  localparam logic [3:0] SLOT_LAST     = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_COLS  = 3'd0;
  localparam logic [2:0] CFG_NUM_ROWS  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_X  = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd3;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd4;
  localparam logic [2:0] CFG_INV_SIZE  = 3'd5;

  // Axis selection: bit 0 picks y, bit 1 picks the new position
  localparam logic [1:0] AX_OLD_X = 2'd0;
  localparam logic [1:0] AX_OLD_Y = 2'd1;
  localparam logic [1:0] AX_NEW_X = 2'd2;
  localparam logic [1:0] AX_NEW_Y = 2'd3;

  typedef enum logic [2:0] {
    RAM_NONE,
    RAM_CLEAR,
    RAM_RD_DST,
    RAM_WR_SRC_EMPTY,
    RAM_WR_DST_SET,
    RAM_RD_NB
  } ram_op_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        item_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic [11:0]        cell_a;
    logic [11:0]        cell_b;
  } in_t;

  typedef struct packed {
    logic [11:0]        cell_index;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic [3:0]         slot;
    logic [1:0]         slot_state;
    logic [15:0]        occupant_id;
    logic [3:0]         neighbour_count;
    logic               status;
    logic               last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       ax_sub;
    logic       ax_lo;
    logic       ax_hi;
    logic       ax_end;
    logic [1:0] ax_sel;
    logic       cell_calc;
    logic       div_start;
    logic       div_step;
    logic       pos_mul;
    ram_op_e    ram_op;
    logic       set_refuse;
    logic       res_load;
    logic       nb_load;
    logic [3:0] slot;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       clr_last;
    logic       div_last;
    logic       cells_equal;
    logic       grid_ok;
    logic       dst_occupied;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/ugot_ram.sv
// Generic single-port RAM with registered read data.
module ugot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ugot_ctrl.sv
// Controller state machine sequencing the occupancy table datapath.
module ugot_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ugot_pkg::sts_t sts_i,
  output ugot_pkg::cmd_t cmd_o
);
  import ugot_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_AX_SUB, S_AX_LO, S_AX_HI, S_AX_END,
    S_CELL, S_MV_EQ, S_INS_WR, S_MV_RD, S_MV_CHK, S_MV_CLR, S_MV_SET,
    S_RESULT, S_DIV, S_POS_MUL, S_NB_RD, S_NB_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic [3:0] slot_q, slot_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ax_d       = ax_q;
    slot_d     = slot_q;
    cmd_o      = '0;
    cmd_o.ram_op = RAM_NONE;
    cmd_o.ax_sel = ax_q;
    cmd_o.slot   = slot_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.ram_op = RAM_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.kind)
          KIND_INSERT, KIND_MOVE_POS: begin
            ax_d    = AX_OLD_X;
            state_d = S_AX_SUB;
          end
          KIND_MOVE_CELL: begin
            if (sts_i.grid_ok) begin
              state_d = S_MV_RD;
            end else begin
              cmd_o.set_refuse = 1'b1;
              state_d = S_RESULT;
            end
          end
          KIND_QUERY, KIND_CELL_POS: begin
            cmd_o.div_start = 1'b1;
            state_d = S_DIV;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_AX_SUB: begin
        cmd_o.ax_sub = 1'b1;
        state_d = S_AX_LO;
      end
      S_AX_LO: begin
        cmd_o.ax_lo = 1'b1;
        state_d = S_AX_HI;
      end
      S_AX_HI: begin
        cmd_o.ax_hi = 1'b1;
        state_d = S_AX_END;
      end
      S_AX_END: begin
        cmd_o.ax_end = 1'b1;
        if ((sts_i.kind == KIND_INSERT && ax_q == AX_OLD_Y) || ax_q == AX_NEW_Y) begin
          state_d = S_CELL;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_AX_SUB;
        end
      end
      S_CELL: begin
        cmd_o.cell_calc = 1'b1;
        state_d = (sts_i.kind == KIND_INSERT) ? S_INS_WR : S_MV_EQ;
      end
      S_MV_EQ: begin
        state_d = sts_i.cells_equal ? S_RESULT : S_MV_RD;
      end
      S_INS_WR: begin
        cmd_o.ram_op = RAM_WR_DST_SET;
        state_d = S_RESULT;
      end
      S_MV_RD: begin
        cmd_o.ram_op = RAM_RD_DST;
        state_d = S_MV_CHK;
      end
      S_MV_CHK: begin
        if (sts_i.dst_occupied) begin
          cmd_o.set_refuse = 1'b1;
          state_d = S_RESULT;
        end else begin
          state_d = S_MV_CLR;
        end
      end
      S_MV_CLR: begin
        cmd_o.ram_op = RAM_WR_SRC_EMPTY;
        state_d = S_MV_SET;
      end
      S_MV_SET: begin
        cmd_o.ram_op = RAM_WR_DST_SET;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          if (sts_i.kind == KIND_QUERY) begin
            slot_d  = SLOT_FIRST;
            state_d = S_NB_RD;
          end else begin
            state_d = S_POS_MUL;
          end
        end
      end
      S_POS_MUL: begin
        cmd_o.pos_mul = 1'b1;
        state_d = S_RESULT;
      end
      S_NB_RD: begin
        cmd_o.ram_op = RAM_RD_NB;
        state_d = S_NB_OUT;
      end
      S_NB_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.nb_load = 1'b1;
          if (slot_q == SLOT_LAST) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = (slot_q == SLOT_BEFORE_C) ? SLOT_AFTER_C : slot_q + 4'd1;
            state_d = S_NB_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ax_q    <= AX_OLD_X;
      slot_q  <= SLOT_FIRST;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      slot_q  <= slot_d;
    end
  end

endmodule

// File: sv/ugot_dp.sv
// Datapath: configuration, position mapping, divider, cell store and result word.
module ugot_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [23:0]    cfg_data_i,
  input  ugot_pkg::in_t  in_i,
  input  ugot_pkg::cmd_t cmd_i,
  output ugot_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ugot_pkg::out_t out_o
);
  import ugot_pkg::*;

  // Configuration registers
  logic [6:0]         num_cols_q, num_rows_q;
  logic signed [23:0] origin_x_q, origin_y_q;
  logic [22:0]        cell_size_q;
  logic [23:0]        inv_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q  <= 7'd64;
      num_rows_q  <= 7'd64;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= 23'd256;
      inv_size_q  <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_COLS:  num_cols_q  <= cfg_data_i[6:0];
        CFG_NUM_ROWS:  num_rows_q  <= cfg_data_i[6:0];
        CFG_ORIGIN_X:  origin_x_q  <= cfg_data_i;
        CFG_ORIGIN_Y:  origin_y_q  <= cfg_data_i;
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i[22:0];
        CFG_INV_SIZE:  inv_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry, saturated to [1, MAX_SIDE]
  logic [LIM_W-1:0] cols, rows;
  logic [12:0]      area;
  always_comb begin
    if (num_cols_q == '0) cols = LIM_W'(1);
    else if (num_cols_q > 7'(MAX_SIDE)) cols = LIM_W'(MAX_SIDE);
    else cols = num_cols_q[LIM_W-1:0];
    if (num_rows_q == '0) rows = LIM_W'(1);
    else if (num_rows_q > 7'(MAX_SIDE)) rows = LIM_W'(MAX_SIDE);
    else rows = num_rows_q[LIM_W-1:0];
  end
  assign area = 13'(cols * rows);

  // Captured input word and per-item flags
  in_t        in_q;
  logic       refuse_q;
  logic [3:0] count_q;

  // Axis mapping registers
  logic [23:0] ax_d_q;
  logic        ax_pos_q;
  logic [35:0] ax_lo_q;
  logic [47:0] ax_p_q;
  logic [SIDE_W-1:0] col_p_q, row_p_q, col_n_q, row_n_q;
  logic [CELL_W-1:0] cell_p_q, cell_n_q;

  // Divider registers
  logic [6:0]  div_rem_q;
  logic [11:0] div_quo_q;
  logic [3:0]  div_cnt_q;

  // Corner products
  logic [28:0] prod_x_q;
  logic [34:0] prod_y_q;

  logic [CELL_W-1:0] clr_cnt_q;
  logic              out_valid_q;
  out_t              out_q;

  // Axis subtract
  logic signed [23:0] ax_raw, ax_org;
  logic [24:0]        ax_diff;
  always_comb begin
    case (cmd_i.ax_sel)
      AX_OLD_X: ax_raw = in_q.pos_x;
      AX_OLD_Y: ax_raw = in_q.pos_y;
      AX_NEW_X: ax_raw = in_q.new_x;
      default:  ax_raw = in_q.new_y;
    endcase
    ax_org  = cmd_i.ax_sel[0] ? origin_y_q : origin_x_q;
    ax_diff = {ax_raw[23], ax_raw} - {ax_org[23], ax_org};
  end

  // Axis clamp
  logic [LIM_W-1:0]  ax_lim_m1;
  logic [23:0]       ax_c;
  logic [SIDE_W-1:0] ax_cell;
  always_comb begin
    ax_lim_m1 = (cmd_i.ax_sel[0] ? rows : cols) - LIM_W'(1);
    ax_c      = ax_p_q[47:24];
    if (!ax_pos_q) ax_cell = '0;
    else if (ax_c > 24'(ax_lim_m1)) ax_cell = ax_lim_m1[SIDE_W-1:0];
    else ax_cell = ax_c[SIDE_W-1:0];
  end

  // Divider step: restoring, one quotient bit per cycle
  logic [7:0] div_trial;
  logic       div_ge;
  assign div_trial = {div_rem_q, in_q.cell_a[div_cnt_q]};
  assign div_ge    = (div_trial >= 8'(cols));

  // Neighbour coordinates for the current slot
  logic signed [7:0]  nb_x;
  logic signed [13:0] nb_y;
  logic [1:0]         nb_dx, nb_dy;
  logic               nb_inside;
  logic [CELL_W-1:0]  nb_idx;
  always_comb begin
    case (cmd_i.slot)
      4'd0, 4'd3, 4'd6: nb_dx = 2'd0;
      4'd1, 4'd4, 4'd7: nb_dx = 2'd1;
      default:          nb_dx = 2'd2;
    endcase
    case (cmd_i.slot)
      4'd0, 4'd1, 4'd2: nb_dy = 2'd0;
      4'd3, 4'd4, 4'd5: nb_dy = 2'd1;
      default:          nb_dy = 2'd2;
    endcase
    nb_x = $signed({2'b00, div_rem_q[SIDE_W-1:0]}) + $signed({6'b0, nb_dx}) - 8'sd1;
    nb_y = $signed({2'b00, div_quo_q}) + $signed({12'b0, nb_dy}) - 14'sd1;
    nb_inside = (13'(in_q.cell_a) < area) && !nb_x[7] && (nb_x < $signed({1'b0, cols}))
                && !nb_y[13] && (nb_y < $signed({7'b0, rows}));
    nb_idx = CELL_W'(nb_y[SIDE_W-1:0] * cols) + CELL_W'(nb_x[SIDE_W-1:0]);
  end

  // Store addressing
  logic [CELL_W-1:0] dst, src, ram_addr;
  logic              ram_we, ram_re;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  always_comb begin
    case (in_q.kind)
      KIND_INSERT:   dst = cell_p_q;
      KIND_MOVE_POS: dst = cell_n_q;
      default:       dst = in_q.cell_b;
    endcase
    src       = (in_q.kind == KIND_MOVE_POS) ? cell_p_q : in_q.cell_a;
    ram_addr  = dst;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = '0;
    case (cmd_i.ram_op)
      RAM_CLEAR: begin
        ram_addr = clr_cnt_q;
        ram_we   = 1'b1;
      end
      RAM_RD_DST: ram_re = 1'b1;
      RAM_WR_SRC_EMPTY: begin
        ram_addr = src;
        ram_we   = 1'b1;
      end
      RAM_WR_DST_SET: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, in_q.item_id};
      end
      RAM_RD_NB: begin
        ram_addr = nb_idx;
        ram_re   = 1'b1;
      end
      default: ;
    endcase
  end

  ugot_ram #(.WIDTH(RAM_W), .DEPTH(MAX_CELLS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Corner position with saturation
  logic signed [36:0] sum_x, sum_y;
  logic signed [23:0] sat_x, sat_y;
  always_comb begin
    sum_x = $signed({8'b0, prod_x_q}) + 37'(origin_x_q);
    sum_y = $signed({2'b0, prod_y_q}) + 37'(origin_y_q);
    if (sum_x > 37'sd8388607) sat_x = 24'sh7FFFFF;
    else if (sum_x < -37'sd8388608) sat_x = 24'sh800000;
    else sat_x = sum_x[23:0];
    if (sum_y > 37'sd8388607) sat_y = 24'sh7FFFFF;
    else if (sum_y < -37'sd8388608) sat_y = 24'sh800000;
    else sat_y = sum_y[23:0];
  end

  // Result word assembly
  out_t       res;
  logic [3:0] nb_count;
  logic       nb_occ;
  always_comb begin
    res      = '0;
    nb_occ   = nb_inside && ram_rdata[RAM_W-1];
    nb_count = count_q + {3'b0, nb_occ};
    if (cmd_i.nb_load) begin
      res.slot            = cmd_i.slot;
      res.slot_state      = !nb_inside ? SLOT_OUTSIDE : (nb_occ ? SLOT_OCCUPIED : SLOT_EMPTY);
      res.occupant_id     = nb_occ ? ram_rdata[ID_WIDTH-1:0] : '0;
      res.neighbour_count = nb_count;
      res.last            = (cmd_i.slot == SLOT_LAST);
    end else begin
      res.last = 1'b1;
      case (in_q.kind)
        KIND_INSERT:   res.cell_index = cell_p_q;
        KIND_MOVE_POS: begin
          res.cell_index = cell_n_q;
          res.status     = refuse_q;
        end
        KIND_MOVE_CELL: begin
          res.cell_index = in_q.cell_b;
          res.status     = refuse_q;
        end
        default: begin
          res.out_x = sat_x;
          res.out_y = sat_y;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      refuse_q    <= 1'b0;
      count_q     <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (cmd_i.ram_op == RAM_CLEAR) clr_cnt_q <= clr_cnt_q + CELL_W'(1);
      if (cmd_i.res_load || cmd_i.nb_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.capture) refuse_q <= 1'b0;
      else if (cmd_i.set_refuse) refuse_q <= 1'b1;
      if (cmd_i.capture) count_q <= '0;
      else if (cmd_i.nb_load) count_q <= nb_count;
      if (cmd_i.div_start) div_cnt_q <= 4'd11;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q - 4'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_i;
    if (cmd_i.ax_sub) begin
      ax_d_q   <= ax_diff[23:0];
      ax_pos_q <= !ax_diff[24] && (ax_diff != '0);
    end
    if (cmd_i.ax_lo) ax_lo_q <= ax_d_q * inv_size_q[11:0];
    if (cmd_i.ax_hi) ax_p_q <= 48'(ax_lo_q) + (48'(ax_d_q * inv_size_q[23:12]) << 12);
    if (cmd_i.ax_end) begin
      case (cmd_i.ax_sel)
        AX_OLD_X: col_p_q <= ax_cell;
        AX_OLD_Y: row_p_q <= ax_cell;
        AX_NEW_X: col_n_q <= ax_cell;
        default:  row_n_q <= ax_cell;
      endcase
    end
    if (cmd_i.cell_calc) begin
      cell_p_q <= CELL_W'(row_p_q * cols) + CELL_W'(col_p_q);
      cell_n_q <= CELL_W'(row_n_q * cols) + CELL_W'(col_n_q);
    end
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? 7'(div_trial - 8'(cols)) : div_trial[6:0];
      div_quo_q <= {div_quo_q[10:0], div_ge};
    end
    if (cmd_i.pos_mul) begin
      prod_x_q <= div_rem_q[SIDE_W-1:0] * cell_size_q;
      prod_y_q <= div_quo_q * cell_size_q;
    end
    if (cmd_i.res_load || cmd_i.nb_load) out_q <= res;
  end

  // Status back to the controller
  assign sts_o.kind         = in_q.kind;
  assign sts_o.clr_last     = &clr_cnt_q;
  assign sts_o.div_last     = (div_cnt_q == '0);
  assign sts_o.cells_equal  = (cell_p_q == cell_n_q);
  assign sts_o.grid_ok      = (13'(in_q.cell_a) < area) && (13'(in_q.cell_b) < area);
  assign sts_o.dst_occupied = ram_rdata[RAM_W-1];
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: sv/uniform_grid_occupancy_table_core.sv
// Top level: uniform grid occupancy table with valid/ready word channels.
// One item at a time, set by the shared axis multiplier, the 12-step divider
// and the single-port cell store.
// After reset the store is swept empty, all 4096 cells written, before an item is accepted.
module uniform_grid_occupancy_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [23:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ugot_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ugot_pkg::out_t out_o
);
  import ugot_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ugot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ugot_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: tb/uniform_grid_occupancy_table_core_test.sv
// Self-checking bench for the grid occupancy table: predicts each output word.
module uniform_grid_occupancy_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ugot_pkg::*;

  localparam int unsigned STALL_LIMIT = 40000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_o;

  uniform_grid_occupancy_table_core dut (.*);

  // grid model
  logic [6:0]         g_cols, g_rows;
  logic signed [23:0] g_org_x, g_org_y;
  logic [22:0]        g_csize;
  logic [23:0]        g_inv;
  bit                 occ [MAX_CELLS];
  logic [15:0]        owner [MAX_CELLS];

  out_t  expected_words[$];
  int    n_errors;
  bit    rx_hold;
  int    idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int eff_cols();
    if (g_cols < 1) return 1;
    return (g_cols > MAX_SIDE) ? int'(MAX_SIDE) : int'(g_cols);
  endfunction

  function automatic int eff_rows();
    if (g_rows < 1) return 1;
    return (g_rows > MAX_SIDE) ? int'(MAX_SIDE) : int'(g_rows);
  endfunction

  function automatic bit in_grid(longint idx);
    return idx < eff_cols() * eff_rows() && idx < MAX_CELLS;
  endfunction

  function automatic longint axis_cell(logic signed [23:0] raw,
                                       logic signed [23:0] org, int lim);
    longint d, p, c;
    d = longint'(raw) - longint'(org);
    if (d <= 0) return 0;
    p = d * longint'(g_inv);
    c = p >>> 24;
    return (c > lim - 1) ? longint'(lim - 1) : c;
  endfunction

  function automatic longint grid_cell(logic signed [23:0] x, logic signed [23:0] y);
    return axis_cell(y, g_org_y, eff_rows()) * eff_cols()
           + axis_cell(x, g_org_x, eff_cols());
  endfunction

  function automatic logic [23:0] sat24(longint v);
    if (v > 8388607) return 24'h7fffff;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // predict output words of one item and update the grid
  task automatic predict_grid(in_t it);
    out_t   w;
    longint p, n, cols, col, row, x, y, nidx;
    int     cnt;
    cols = eff_cols();
    w = '0;
    w.last = 1'b1;
    case (it.kind)
      KIND_INSERT: begin
        p = grid_cell(it.pos_x, it.pos_y);
        if (p < MAX_CELLS) begin
          owner[p] = it.item_id;
          occ[p] = 1'b1;
        end
        w.cell_index = p[11:0];
        expected_words.push_back(w);
      end
      KIND_MOVE_POS: begin
        p = grid_cell(it.pos_x, it.pos_y);
        n = grid_cell(it.new_x, it.new_y);
        if (p != n) begin
          if (p >= MAX_CELLS || n >= MAX_CELLS || occ[n]) w.status = 1'b1;
          else begin
            occ[p] = 1'b0;
            owner[n] = it.item_id;
            occ[n] = 1'b1;
          end
        end
        w.cell_index = n[11:0];
        expected_words.push_back(w);
      end
      KIND_MOVE_CELL: begin
        if (!in_grid(it.cell_a) || !in_grid(it.cell_b) || occ[it.cell_b]) w.status = 1'b1;
        else begin
          occ[it.cell_a] = 1'b0;
          owner[it.cell_b] = it.item_id;
          occ[it.cell_b] = 1'b1;
        end
        w.cell_index = it.cell_b;
        expected_words.push_back(w);
      end
      KIND_QUERY: begin
        col = it.cell_a % cols;
        row = it.cell_a / cols;
        cnt = 0;
        for (int s = 0; s < 9; s++) begin
          if (s == 4) continue;
          w = '0;
          w.slot = s[3:0];
          x = col + s % 3 - 1;
          y = row + s / 3 - 1;
          if (in_grid(it.cell_a) && x >= 0 && x < cols && y >= 0 && y < eff_rows()) begin
            nidx = y * cols + x;
            if (nidx < MAX_CELLS && occ[nidx]) begin
              w.slot_state = SLOT_OCCUPIED;
              w.occupant_id = owner[nidx];
              cnt++;
            end else w.slot_state = SLOT_EMPTY;
          end else w.slot_state = SLOT_OUTSIDE;
          w.neighbour_count = cnt[3:0];
          w.last = (s == 8);
          expected_words.push_back(w);
        end
      end
      KIND_CELL_POS: begin
        col = it.cell_a % cols;
        row = it.cell_a / cols;
        w.out_x = sat24(col * longint'(g_csize) + longint'(g_org_x));
        w.out_y = sat24(row * longint'(g_csize) + longint'(g_org_y));
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  // random gap, mostly short
  task automatic rand_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk_i);
  endtask

  // offer one word and wait for acceptance
  task automatic send_word(in_t it, bit gaps = 1);
    if (gaps) rand_gap();
    in_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_grid(it);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NUM_COLS:  g_cols  = val[6:0];
      CFG_NUM_ROWS:  g_rows  = val[6:0];
      CFG_ORIGIN_X:  g_org_x = val;
      CFG_ORIGIN_Y:  g_org_y = val;
      CFG_CELL_SIZE: g_csize = val[22:0];
      CFG_INV_SIZE:  g_inv   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_grid(int c, int r, int ox, int oy, int cs, int inv);
    write_reg(CFG_NUM_COLS, 24'(c));
    write_reg(CFG_NUM_ROWS, 24'(r));
    write_reg(CFG_ORIGIN_X, 24'(ox));
    write_reg(CFG_ORIGIN_Y, 24'(oy));
    write_reg(CFG_CELL_SIZE, 24'(cs));
    write_reg(CFG_INV_SIZE, 24'(inv));
  endtask

  function automatic in_t make_word(logic [2:0] k);
    in_t it;
    it = '0;
    it.kind = k;
    it.item_id = 16'($urandom);
    return it;
  endfunction

  // position near the grid, mostly in range
  function automatic logic [23:0] grid_pos();
    if ($urandom_range(0, 7) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 4095) * 64 - 512);
  endfunction

  function automatic logic [11:0] grid_idx();
    int n;
    n = eff_cols() * eff_rows();
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    return 12'($urandom_range(0, n - 1));
  endfunction

  function automatic in_t random_word();
    in_t it;
    int  r;
    r = $urandom_range(0, 99);
    if (r < 25)      it = make_word(KIND_INSERT);
    else if (r < 45) it = make_word(KIND_MOVE_POS);
    else if (r < 62) it = make_word(KIND_MOVE_CELL);
    else if (r < 82) it = make_word(KIND_QUERY);
    else if (r < 96) it = make_word(KIND_CELL_POS);
    else             it = make_word(3'($urandom_range(5, 7)));
    it.pos_x = grid_pos();
    it.pos_y = grid_pos();
    it.new_x = grid_pos();
    it.new_y = grid_pos();
    it.cell_a = grid_idx();
    it.cell_b = grid_idx();
    return it;
  endfunction

  // directed: field extremes, every kind, special cases
  task automatic test_directed();
    in_t it;
    it = make_word(KIND_INSERT);
    it.item_id = 16'hffff;
    send_word(it);
    it.pos_x = 24'h7fffff; it.pos_y = 24'h7fffff; it.item_id = 16'h0000;
    send_word(it);
    it.pos_x = 24'h800000; it.pos_y = 24'h000300;
    send_word(it);
    it = make_word(KIND_MOVE_POS);
    it.new_x = 24'h000100;
    send_word(it);
    it.pos_x = 24'h000100; it.new_x = 24'h7fffff; it.new_y = 24'h7fffff;
    send_word(it);
    it.pos_x = 24'h000500; it.new_x = 24'h000500;
    send_word(it);
    it = make_word(KIND_MOVE_CELL);
    it.cell_a = 12'd1; it.cell_b = 12'd2;
    send_word(it);
    it.cell_b = 12'd4095;
    send_word(it);
    it.cell_a = 12'd2; it.cell_b = 12'd192;
    send_word(it);
    it = make_word(KIND_QUERY);
    it.cell_a = 12'd0;
    send_word(it);
    it.cell_a = 12'd129;
    send_word(it);
    it.cell_a = 12'd4095;
    send_word(it);
    it = make_word(KIND_CELL_POS);
    it.cell_a = 12'd4095;
    send_word(it);
    it = make_word(3'd7);
    send_word(it);
    it = make_word(3'd5);
    send_word(it);
    wait_drained();
    // extreme geometry, cell position beyond the grid, saturation
    set_grid(0, 127, 24'h7fffff, 24'h800000, 23'h7fffff, 0);
    it = make_word(KIND_CELL_POS);
    it.cell_a = 12'hfff;
    send_word(it);
    it = make_word(KIND_INSERT);
    it.pos_x = 24'h123456; it.pos_y = 24'h7fffff;
    send_word(it);
    it = make_word(KIND_QUERY);
    it.cell_a = 12'd5;
    send_word(it);
    it = make_word(KIND_MOVE_CELL);
    it.cell_a = 12'd0; it.cell_b = 12'd63;
    send_word(it);
    wait_drained();
  endtask

  // random phase under one geometry
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    in_t it;
    rx_hold = 1'b1;
    for (int i = 0; i < 12; i++) begin
      it = make_word(KIND_QUERY);
      it.cell_a = grid_idx();
      send_word(it, 0);
    end
    rx_hold = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NUM_COLS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_i = '0;
    rx_hold = 1'b0;
    n_errors = 0;
    g_cols = 64; g_rows = 64; g_org_x = 0; g_org_y = 0;
    g_csize = 256; g_inv = 65536;
    foreach (occ[i]) occ[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_grid(64, 64, 0, 0, 256, 65536);
    test_random(100);
    set_grid(5, 3, -24'sd1000, 24'sd700, 384, 43691);
    test_random(80);
    test_backpressure();
    set_grid(1, 1, 0, 0, 1, 16777215);
    test_random(30);
    set_grid(8, 8, -24'sd40000, -24'sd40000, 1280, 13107);
    test_random(130);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // receiver stalls
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat (1 + (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2)))
          @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %p", out_o);
        n_errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_o.cell_index !== w.cell_index) begin
          $error("cell_index exp %0d got %0d", w.cell_index, out_o.cell_index); n_errors++; end
        if (out_o.out_x !== w.out_x) begin
          $error("out_x exp %0d got %0d", w.out_x, out_o.out_x); n_errors++; end
        if (out_o.out_y !== w.out_y) begin
          $error("out_y exp %0d got %0d", w.out_y, out_o.out_y); n_errors++; end
        if (out_o.slot !== w.slot) begin
          $error("slot exp %0d got %0d", w.slot, out_o.slot); n_errors++; end
        if (out_o.slot_state !== w.slot_state) begin
          $error("slot_state exp %0d got %0d", w.slot_state, out_o.slot_state); n_errors++; end
        if (out_o.occupant_id !== w.occupant_id) begin
          $error("occupant_id exp %0d got %0d", w.occupant_id, out_o.occupant_id);
          n_errors++;
        end
        if (out_o.neighbour_count !== w.neighbour_count) begin
          $error("neighbour_count exp %0d got %0d", w.neighbour_count,
                 out_o.neighbour_count);
          n_errors++;
        end
        if (out_o.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_o.status); n_errors++; end
        if (out_o.last !== w.last) begin
          $error("last exp %0d got %0d", w.last, out_o.last); n_errors++; end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule

// File: sim.f
sv/ugot_pkg.sv
sv/ugot_ram.sv
sv/ugot_ctrl.sv
sv/ugot_dp.sv
sv/uniform_grid_occupancy_table_core.sv
tb/uniform_grid_occupancy_table_core_test.sv
